### rtl/positional_list_store_core_assert.svh
// ----------------------------------------------------------------------------
// positional_list_store_core_assert.svh
// Assertion macros used by the list store core.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define PLSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/plsc_pkg.sv
// ----------------------------------------------------------------------------
// plsc_pkg
// Types and constants of the positional list store.
// ----------------------------------------------------------------------------
package plsc_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        RQ_PUSH_FRONT = 4'd0,
        RQ_PUSH_BACK  = 4'd1,
        RQ_INSERT     = 4'd2,
        RQ_POP_FRONT  = 4'd3,
        RQ_POP_BACK   = 4'd4,
        RQ_ERASE      = 4'd5,
        RQ_REMOVE     = 4'd6,
        RQ_FIND       = 4'd7,
        RQ_READ       = 4'd8,
        RQ_REVERSE    = 4'd9,
        RQ_CLEAR      = 4'd10
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD      = 2'd0,
        CM_INS       = 2'd1,
        CM_DEL       = 2'd2,
        CM_DEL_MATCH = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       rev;
    } t_cell_cmd;

endpackage

### rtl/plsc_cell.sv
// ----------------------------------------------------------------------------
// plsc_cell
// One storage cell of the list row: holds, loads or takes a neighbor's word,
// and joins the match chains that locate the first or last hit.
// ----------------------------------------------------------------------------
module plsc_cell
    import plsc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = 5,
    parameter int CW         = 6,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [AW-1:0]         i_ppos,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_pre,
    input  logic                  i_suf,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_pre,
    output logic                  o_suf,
    output logic                  o_sel
);

    localparam logic [AW-1:0] IDX_A = AW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_hit;
    logic                  w_shift;

    assign w_hit   = (r_data == i_value) && (IDX_C < i_count);
    assign o_pre   = i_pre | w_hit;
    assign o_suf   = i_suf | w_hit;
    assign o_sel   = w_hit && (i_cmd.rev ? !i_suf : !i_pre);
    assign w_shift = i_cmd.rev ? !i_suf : o_pre;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            CM_INS: begin
                if (IDX_A > i_ppos) begin
                    n_data = i_left;
                end else if (IDX_A == i_ppos) begin
                    n_data = i_value;
                end
            end
            CM_DEL: begin
                if (IDX_A >= i_ppos) begin
                    n_data = i_right;
                end
            end
            CM_DEL_MATCH: begin
                if (w_shift) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### rtl/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core: ordered list store on a shifting row of cells
// An accepted request passes through S_EXEC, where every cell compares and
// shifts at once, then S_RESP with o_valid; start is taken again in S_RESP.
// Synchronous active-low reset empties the list; cell contents are not reset.
// ----------------------------------------------------------------------------
`include "positional_list_store_core_assert.svh"

module positional_list_store_core
    import plsc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = $clog2(CAPACITY),
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   i_req_type,
    input  logic [CW-1:0]                i_position,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_data_out,
    output logic signed [CW-1:0]         o_found_index,
    output logic [CW-1:0]                o_count,
    output logic signed [DATA_WIDTH-1:0] o_front_value,
    output logic signed [DATA_WIDTH-1:0] o_back_value,
    output logic                         o_is_empty
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    logic [CW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rev;
    logic                  n_rev;
    t_status               r_status;
    t_status               n_status;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] n_rdata;
    logic [CW-1:0]         r_fidx;
    logic [CW-1:0]         n_fidx;

    logic                  w_accept;
    logic                  w_exec;
    logic                  w_full;
    logic [CW-1:0]         w_lpos;
    logic [CW-1:0]         w_ins_phys;
    logic [CW-1:0]         w_del_phys;
    logic [AW-1:0]         w_ppos;
    t_cell_cmd             w_cmd;
    logic [AW-1:0]         w_match_idx;
    logic                  w_any;
    logic [AW-1:0]         w_last;
    logic                  w_has;

    logic [DATA_WIDTH-1:0] w_cells [CAPACITY];
    logic [CAPACITY:0]     w_pre;
    logic [CAPACITY:0]     w_suf;
    logic [CAPACITY-1:0]   w_sel;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = start ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy    = 1'b0;
        o_valid = 1'b0;
        w_exec  = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                busy   = 1'b1;
                w_exec = 1'b1;
            end
            S_RESP:  o_valid = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CAP_C);

    // logical position to physical cell index
    always_comb begin
        case (r_req) inside
            RQ_PUSH_FRONT, RQ_POP_FRONT: w_lpos = '0;
            RQ_PUSH_BACK:                w_lpos = r_count;
            RQ_POP_BACK:                 w_lpos = r_count - CW'(1);
            default:                     w_lpos = r_pos;
        endcase
    end

    assign w_ins_phys = r_rev ? (r_count - w_lpos) : w_lpos;
    assign w_del_phys = r_rev ? (r_count - CW'(1) - w_lpos) : w_lpos;

    always_comb begin
        w_match_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match_idx = w_match_idx | (w_sel[i] ? AW'(i) : '0);
        end
    end

    assign w_any = |w_sel;

    // execute
    always_comb begin
        n_count    = r_count;
        n_rev      = r_rev;
        n_status   = ST_OK;
        n_rdata    = '0;
        n_fidx     = '1;
        w_cmd.mode = CM_HOLD;
        w_cmd.rev  = r_rev;
        w_ppos     = '0;
        if (w_exec) begin
            case (r_req) inside
                RQ_PUSH_FRONT, RQ_PUSH_BACK, RQ_INSERT: begin
                    if ((r_req == RQ_INSERT) && (r_pos > r_count)) begin
                        n_status = ST_RANGE;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.mode = CM_INS;
                        w_ppos     = w_ins_phys[AW-1:0];
                        n_count    = r_count + CW'(1);
                    end
                end
                RQ_POP_FRONT, RQ_POP_BACK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_cmd.mode = CM_DEL;
                        w_ppos     = w_del_phys[AW-1:0];
                        n_count    = r_count - CW'(1);
                    end
                end
                RQ_ERASE: begin
                    if (r_pos >= r_count) begin
                        n_status = ST_RANGE;
                    end else begin
                        w_cmd.mode = CM_DEL;
                        w_ppos     = w_del_phys[AW-1:0];
                        n_count    = r_count - CW'(1);
                    end
                end
                RQ_REMOVE: begin
                    if (w_any) begin
                        w_cmd.mode = CM_DEL_MATCH;
                        n_count    = r_count - CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                RQ_FIND: begin
                    if (w_any) begin
                        n_fidx = r_rev ? (r_count - CW'(1) - CW'(w_match_idx))
                                       : CW'(w_match_idx);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                RQ_READ: begin
                    if (r_pos >= r_count) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_rdata = w_cells[w_del_phys[AW-1:0]];
                    end
                end
                RQ_REVERSE: n_rev = !r_rev;
                RQ_CLEAR: begin
                    n_count = '0;
                    n_rev   = 1'b0;
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_req_type);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
            r_fidx   <= n_fidx;
        end
    end

    // cell row
    assign w_pre[0]        = 1'b0;
    assign w_suf[CAPACITY] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cells[g+1];
        end

        plsc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AW         (AW),
            .CW         (CW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_ppos  (w_ppos),
            .i_count (r_count),
            .i_value (r_val),
            .i_left  (w_left),
            .i_right (w_right),
            .i_pre   (w_pre[g]),
            .i_suf   (w_suf[g+1]),
            .o_data  (w_cells[g]),
            .o_pre   (w_pre[g+1]),
            .o_suf   (w_suf[g]),
            .o_sel   (w_sel[g])
        );
    end

    // result word
    assign w_has = (r_count != '0);
    assign w_last = AW'(r_count - CW'(1));

    assign o_status      = r_status;
    assign o_data_out    = r_rdata;
    assign o_found_index = r_fidx;
    assign o_count       = r_count;
    assign o_is_empty    = !w_has;
    assign o_front_value = w_has ? w_cells[r_rev ? w_last : AW'(0)] : '0;
    assign o_back_value  = w_has ? w_cells[r_rev ? AW'(0) : w_last] : '0;

    `PLSC_ASSERT_NEXT(a_accept_exec, start && !busy, busy && !o_valid, "accepted word not executed")
    `PLSC_ASSERT_NOW(a_count_bound, o_valid, o_count <= CAP_C, "count above capacity")
    `PLSC_ASSERT_NOW(a_fidx_idle, o_valid && (r_req != RQ_FIND), &o_found_index, "stray found index")
    `PLSC_ASSERT_NOW(a_clear_empty, o_valid && (r_req == RQ_CLEAR), o_is_empty, "clear left data")

endmodule
